@@ rtl/hpm_pkg.sv @@
// ----------------------------------------------------------------------------
// hpm_pkg
// Shared widths, register codes, reset values and pipeline sideband type
// for the homography point mapper.
// ----------------------------------------------------------------------------
package hpm_pkg;

   // field and register widths
   localparam int SRC_W              = 12;
   localparam int COORD_MAX          = 16;
   localparam int COORD_BITS_DEFAULT = 12;
   localparam int GAIN_W             = 24;
   localparam int OFFSET_W           = 32;
   localparam int CSR_W              = 48;
   localparam int CSR_INDEX_W        = 3;
   localparam int DST_W              = 32;
   localparam int STATUS_W           = 2;

   // datapath growth over the coordinate width
   localparam int NUM_EXTRA  = 26;   // two Q7.16 products plus a Q15.16 offset
   localparam int DEN_EXTRA  = 34;   // two Q1.30 products plus a Q1.30 offset

   // quotient: 32 result bits plus one rounding bit
   localparam int QUO_W      = 33;
   // numerator Q.16 over denominator Q.30 into Q.8 with one rounding bit
   localparam int FRAC_SHIFT = 23;
   localparam int PRE_SHIFT  = QUO_W - FRAC_SHIFT;

   localparam logic [CSR_W-1:0]    X_GAINS_RESET    = 48'h0000_0001_0000;
   localparam logic [CSR_W-1:0]    Y_GAINS_RESET    = 48'h0100_0000_0000;
   localparam logic [OFFSET_W-1:0] DEN_OFFSET_RESET = 32'h4000_0000;

   localparam logic [DST_W-1:0] DST_MAX = 32'h7FFF_FFFF;
   localparam logic [DST_W-1:0] DST_MIN = 32'h8000_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_GAINS,
      CSR_Y_GAINS,
      CSR_X_OFFSET,
      CSR_Y_OFFSET,
      CSR_DEN_X_TERM,
      CSR_DEN_Y_TERM,
      CSR_DEN_OFFSET
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_ZERO_DEN,
      STATUS_SAT
   } status_type;

   // flags that ride along with the divider stages
   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic ovf_x;
      logic ovf_y;
      logic zero_den;
   } hpm_side_type;

endpackage

@@ rtl/homography_point_mapper_unit.sv @@
// ----------------------------------------------------------------------------
// homography_point_mapper_unit
// Maps a source pixel coordinate through a 3x3 projective matrix and returns
// the mapped coordinate in signed Q23.8 with a status code.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : write-only matrix registers, written while the unit is idle.
//   req_*  : one (src_x, src_y) point per transfer on valid and not stall.
//   rsp_*  : one (dst_x, dst_y, status) result per point, in order.
// Pipeline: a point taken on req_* passes through 1 multiply stage, 1 sum
//   stage, 1 magnitude stage, 1 range check stage, 33 divider stages (one
//   quotient bit each, the remainder compare-subtract sets the stage
//   depth), then the output register, which drives rsp_valid.
// Throughput: one point per cycle while rsp_stall is low.
// Stall: the whole pipeline holds while a result waits in the output
//   register under rsp_stall; req_stall follows, and a new point is taken
//   in the same cycle the waiting result leaves.
// Reset: pipeline valid bits clear, the matrix returns to identity.
// Status: zero denominator gives zero coordinates; a quotient outside the
//   32-bit range saturates.
// ----------------------------------------------------------------------------
module homography_point_mapper_unit
   import hpm_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]        csr_wdata,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [SRC_W-1:0]        req_src_x,
   input  logic [SRC_W-1:0]        req_src_y,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [DST_W-1:0] rsp_dst_x,
   output logic signed [DST_W-1:0] rsp_dst_y,
   output logic [STATUS_W-1:0]     rsp_status
);

   localparam int GP_W  = COORD_BITS + GAIN_W + 1;
   localparam int DP_W  = COORD_BITS + OFFSET_W + 1;
   localparam int NUM_W = COORD_BITS + NUM_EXTRA;
   localparam int DEN_W = COORD_BITS + DEN_EXTRA;
   localparam int CMP_W = DEN_W + PRE_SHIFT;

   localparam logic [QUO_W-1:0] Q_NEG_LIMIT = QUO_W'(64'h8000_0000);
   localparam logic [QUO_W-1:0] Q_POS_LIMIT = QUO_W'(64'h7FFF_FFFF);

   typedef struct packed {
      logic [DST_W-1:0] value;
      logic             sat;
   } coord_result_type;

   // configuration
   logic [CSR_W-1:0]    x_gains_ff, y_gains_ff;
   logic [OFFSET_W-1:0] x_offset_ff, y_offset_ff;
   logic [OFFSET_W-1:0] den_x_term_ff, den_y_term_ff, den_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_gains_ff    <= X_GAINS_RESET;
         y_gains_ff    <= Y_GAINS_RESET;
         x_offset_ff   <= '0;
         y_offset_ff   <= '0;
         den_x_term_ff <= '0;
         den_y_term_ff <= '0;
         den_offset_ff <= DEN_OFFSET_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_X_GAINS:    x_gains_ff    <= csr_wdata;
            CSR_Y_GAINS:    y_gains_ff    <= csr_wdata;
            CSR_X_OFFSET:   x_offset_ff   <= csr_wdata[OFFSET_W-1:0];
            CSR_Y_OFFSET:   y_offset_ff   <= csr_wdata[OFFSET_W-1:0];
            CSR_DEN_X_TERM: den_x_term_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_DEN_Y_TERM: den_y_term_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_DEN_OFFSET: den_offset_ff <= csr_wdata[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   logic signed [GAIN_W-1:0]   a11, a21, a12, a22;
   logic signed [OFFSET_W-1:0] a31, a32, a13, a23, a33;

   assign a11 = signed'(x_gains_ff[GAIN_W-1:0]);
   assign a21 = signed'(x_gains_ff[CSR_W-1:GAIN_W]);
   assign a12 = signed'(y_gains_ff[GAIN_W-1:0]);
   assign a22 = signed'(y_gains_ff[CSR_W-1:GAIN_W]);
   assign a31 = signed'(x_offset_ff);
   assign a32 = signed'(y_offset_ff);
   assign a13 = signed'(den_x_term_ff);
   assign a23 = signed'(den_y_term_ff);
   assign a33 = signed'(den_offset_ff);

   // the whole pipeline moves together unless a result is held at the output
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // stage 1: products
   logic [COORD_MAX+SRC_W-1:0] x_ext, y_ext;
   logic signed [COORD_BITS:0] x_s, y_s;
   logic signed [GP_W-1:0]     pxx_in, pxy_in, pyx_in, pyy_in;
   logic signed [DP_W-1:0]     pdx_in, pdy_in;
   logic signed [GP_W-1:0]     pxx_ff, pxy_ff, pyx_ff, pyy_ff;
   logic signed [DP_W-1:0]     pdx_ff, pdy_ff;
   logic                       v1_ff;

   always_comb begin
      x_ext  = {{COORD_MAX{1'b0}}, req_src_x};
      y_ext  = {{COORD_MAX{1'b0}}, req_src_y};
      x_s    = signed'({1'b0, x_ext[COORD_BITS-1:0]});
      y_s    = signed'({1'b0, y_ext[COORD_BITS-1:0]});
      pxx_in = a11 * x_s;
      pxy_in = a21 * y_s;
      pyx_in = a12 * x_s;
      pyy_in = a22 * y_s;
      pdx_in = a13 * x_s;
      pdy_in = a23 * y_s;
   end

   // stage 2: sums
   logic signed [NUM_W-1:0] nx_in, ny_in, nx_ff, ny_ff;
   logic signed [DEN_W-1:0] dn_in, dn_ff;
   logic                    v2_ff;

   always_comb begin
      nx_in = NUM_W'(pxx_ff) + NUM_W'(pxy_ff) + NUM_W'(a31);
      ny_in = NUM_W'(pyx_ff) + NUM_W'(pyy_ff) + NUM_W'(a32);
      dn_in = DEN_W'(pdx_ff) + DEN_W'(pdy_ff) + DEN_W'(a33);
   end

   // stage 3: magnitudes and signs
   logic [NUM_W-1:0] nmx_in, nmy_in, nmx_ff, nmy_ff;
   logic [DEN_W-1:0] dmag_in, dmag_ff;
   hpm_side_type     side3_in, side3_ff;
   logic             v3_ff;

   always_comb begin
      nmx_in  = nx_ff[NUM_W-1] ? -unsigned'(nx_ff) : unsigned'(nx_ff);
      nmy_in  = ny_ff[NUM_W-1] ? -unsigned'(ny_ff) : unsigned'(ny_ff);
      dmag_in = dn_ff[DEN_W-1] ? -unsigned'(dn_ff) : unsigned'(dn_ff);
      side3_in          = '0;
      side3_in.neg_x    = nx_ff[NUM_W-1] ^ dn_ff[DEN_W-1];
      side3_in.neg_y    = ny_ff[NUM_W-1] ^ dn_ff[DEN_W-1];
      side3_in.zero_den = (dn_ff == '0);
   end

   // stage 4: range check and divider setup
   // the quotient cannot fit in QUO_W bits once n >= d * 2^PRE_SHIFT
   logic [DEN_W-1:0]     rx4_in, ry4_in, rx4_ff, ry4_ff, d4_ff;
   logic [PRE_SHIFT-1:0] lx4_ff, ly4_ff;
   hpm_side_type         side4_in, side4_ff;
   logic                 v4_ff;

   always_comb begin
      side4_in       = side3_ff;
      side4_in.ovf_x = CMP_W'(nmx_ff) >= {dmag_ff, {PRE_SHIFT{1'b0}}};
      side4_in.ovf_y = CMP_W'(nmy_ff) >= {dmag_ff, {PRE_SHIFT{1'b0}}};
      rx4_in         = DEN_W'(nmx_ff >> PRE_SHIFT);
      ry4_in         = DEN_W'(nmy_ff >> PRE_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pxx_ff   <= pxx_in;
         pxy_ff   <= pxy_in;
         pyx_ff   <= pyx_in;
         pyy_ff   <= pyy_in;
         pdx_ff   <= pdx_in;
         pdy_ff   <= pdy_in;
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
         dn_ff    <= dn_in;
         nmx_ff   <= nmx_in;
         nmy_ff   <= nmy_in;
         dmag_ff  <= dmag_in;
         side3_ff <= side3_in;
         rx4_ff   <= rx4_in;
         ry4_ff   <= ry4_in;
         lx4_ff   <= nmx_ff[PRE_SHIFT-1:0];
         ly4_ff   <= nmy_ff[PRE_SHIFT-1:0];
         d4_ff    <= dmag_ff;
         side4_ff <= side4_in;
      end
   end

   // divider stages
   logic             div_valid;
   logic [QUO_W-1:0] div_quo_x, div_quo_y;
   hpm_side_type     div_side;

   hpm_div_pipe #(
      .COORD_BITS (COORD_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v4_ff),
      .in_d      (d4_ff),
      .in_rem_x  (rx4_ff),
      .in_rem_y  (ry4_ff),
      .in_low_x  (lx4_ff),
      .in_low_y  (ly4_ff),
      .in_side   (side4_ff),
      .out_valid (div_valid),
      .out_quo_x (div_quo_x),
      .out_quo_y (div_quo_y),
      .out_side  (div_side)
   );

   // round half away from zero, apply sign, saturate
   function automatic coord_result_type finish_coord(
      input logic [QUO_W-1:0] t,
      input logic             neg,
      input logic             ovf
   );
      logic [QUO_W:0]   t_inc;
      logic [QUO_W-1:0] q;
      coord_result_type r;
      t_inc   = {1'b0, t} + (QUO_W+1)'(1);
      q       = t_inc[QUO_W:1];
      r.value = '0;
      r.sat   = 1'b0;
      priority if (ovf) begin
         r.sat   = 1'b1;
         r.value = neg ? DST_MIN : DST_MAX;
      end else if (q == '0) begin
         r.value = '0;
      end else if (neg) begin
         if (q > Q_NEG_LIMIT) begin
            r.sat   = 1'b1;
            r.value = DST_MIN;
         end else begin
            r.value = DST_W'(-q);
         end
      end else begin
         if (q > Q_POS_LIMIT) begin
            r.sat   = 1'b1;
            r.value = DST_MAX;
         end else begin
            r.value = q[DST_W-1:0];
         end
      end
      finish_coord = r;
   endfunction

   // output register
   coord_result_type fx, fy;
   logic [DST_W-1:0] dst_x_in, dst_y_in, rsp_dst_x_ff, rsp_dst_y_ff;
   status_type       status_in, rsp_status_ff;

   always_comb begin
      fx = finish_coord(div_quo_x, div_side.neg_x, div_side.ovf_x);
      fy = finish_coord(div_quo_y, div_side.neg_y, div_side.ovf_y);
      if (div_side.zero_den) begin
         dst_x_in  = '0;
         dst_y_in  = '0;
         status_in = STATUS_ZERO_DEN;
      end else begin
         dst_x_in  = fx.value;
         dst_y_in  = fy.value;
         status_in = (fx.sat || fy.sat) ? STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_dst_x_ff  <= dst_x_in;
         rsp_dst_y_ff  <= dst_y_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_dst_x  = signed'(rsp_dst_x_ff);
   assign rsp_dst_y  = signed'(rsp_dst_y_ff);
   assign rsp_status = STATUS_W'(rsp_status_ff);

endmodule

@@ rtl/hpm_div_pipe.sv @@
// ----------------------------------------------------------------------------
// hpm_div_pipe
// Pipelined restoring divider, one quotient bit per stage, two numerators
// over one shared denominator. Stalls as a whole on adv low.
// ----------------------------------------------------------------------------
module hpm_div_pipe
   import hpm_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [COORD_BITS+DEN_EXTRA-1:0] in_d,
   input  logic [COORD_BITS+DEN_EXTRA-1:0] in_rem_x,
   input  logic [COORD_BITS+DEN_EXTRA-1:0] in_rem_y,
   input  logic [PRE_SHIFT-1:0]  in_low_x,
   input  logic [PRE_SHIFT-1:0]  in_low_y,
   input  hpm_side_type          in_side,
   output logic                  out_valid,
   output logic [QUO_W-1:0]      out_quo_x,
   output logic [QUO_W-1:0]      out_quo_y,
   output hpm_side_type          out_side
);

   localparam int DEN_W = COORD_BITS + DEN_EXTRA;

   logic                 valid_ff [QUO_W];
   logic [DEN_W-1:0]     d_ff     [QUO_W];
   logic [DEN_W-1:0]     rx_ff    [QUO_W];
   logic [DEN_W-1:0]     ry_ff    [QUO_W];
   logic [PRE_SHIFT-1:0] lx_ff    [QUO_W];
   logic [PRE_SHIFT-1:0] ly_ff    [QUO_W];
   logic [QUO_W-1:0]     qx_ff    [QUO_W];
   logic [QUO_W-1:0]     qy_ff    [QUO_W];
   hpm_side_type         side_ff  [QUO_W];

   logic                 valid_in [QUO_W];
   logic [DEN_W-1:0]     d_in     [QUO_W];
   logic [DEN_W-1:0]     rx_in    [QUO_W];
   logic [DEN_W-1:0]     ry_in    [QUO_W];
   logic [PRE_SHIFT-1:0] lx_in    [QUO_W];
   logic [PRE_SHIFT-1:0] ly_in    [QUO_W];
   logic [QUO_W-1:0]     qx_in    [QUO_W];
   logic [QUO_W-1:0]     qy_in    [QUO_W];
   hpm_side_type         side_in  [QUO_W];

   // shift one dividend bit into the remainder, subtract when it fits
   // returns {quotient bit, next remainder}
   function automatic logic [DEN_W:0] div_step(
      input logic [DEN_W-1:0] rem,
      input logic             bit_in,
      input logic [DEN_W-1:0] d
   );
      logic [DEN_W:0] s;
      logic           ge;
      s  = {rem, bit_in};
      ge = (s >= {1'b0, d});
      div_step = {ge, ge ? DEN_W'(s - {1'b0, d}) : s[DEN_W-1:0]};
   endfunction

   always_comb begin
      logic [DEN_W:0] stx;
      logic [DEN_W:0] sty;
      stx = div_step(in_rem_x, in_low_x[PRE_SHIFT-1], in_d);
      sty = div_step(in_rem_y, in_low_y[PRE_SHIFT-1], in_d);
      valid_in[0] = in_valid;
      d_in[0]     = in_d;
      rx_in[0]    = stx[DEN_W-1:0];
      ry_in[0]    = sty[DEN_W-1:0];
      lx_in[0]    = in_low_x << 1;
      ly_in[0]    = in_low_y << 1;
      qx_in[0]    = QUO_W'(stx[DEN_W]);
      qy_in[0]    = QUO_W'(sty[DEN_W]);
      side_in[0]  = in_side;
      for (int k = 1; k < QUO_W; k++) begin
         stx = div_step(rx_ff[k-1], lx_ff[k-1][PRE_SHIFT-1], d_ff[k-1]);
         sty = div_step(ry_ff[k-1], ly_ff[k-1][PRE_SHIFT-1], d_ff[k-1]);
         valid_in[k] = valid_ff[k-1];
         d_in[k]     = d_ff[k-1];
         rx_in[k]    = stx[DEN_W-1:0];
         ry_in[k]    = sty[DEN_W-1:0];
         lx_in[k]    = lx_ff[k-1] << 1;
         ly_in[k]    = ly_ff[k-1] << 1;
         qx_in[k]    = {qx_ff[k-1][QUO_W-2:0], stx[DEN_W]};
         qy_in[k]    = {qy_ff[k-1][QUO_W-2:0], sty[DEN_W]};
         side_in[k]  = side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUO_W; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         for (int k = 0; k < QUO_W; k++) begin
            valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < QUO_W; k++) begin
            d_ff[k]    <= d_in[k];
            rx_ff[k]   <= rx_in[k];
            ry_ff[k]   <= ry_in[k];
            lx_ff[k]   <= lx_in[k];
            ly_ff[k]   <= ly_in[k];
            qx_ff[k]   <= qx_in[k];
            qy_ff[k]   <= qy_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo_x = qx_ff[QUO_W-1];
   assign out_quo_y = qy_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule
